### design/ipv6c_pkg.sv
// Package for the IPv6 five-tuple mask classifier.
// Holds table sizes, field widths, codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ipv6c_pkg;

    // Table geometry.
    localparam int RULES  = 1024;
    localparam int PARTS  = 5;
    localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int SCAN_W = $clog2(RULES + 1);

    // Field widths fixed by the interface.
    localparam int CNT_W  = 11;
    localparam int MI_W   = 11;
    localparam int RI_W   = 10;
    localparam int PS_W   = 3;
    localparam int WORD_W = 64;

    localparam logic [31:0]     RULES_U    = 32'(RULES);
    localparam logic [MI_W-1:0] MISS_INDEX = RULES_U[MI_W-1:0];

    // Item kinds.
    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // Rule part codes.
    localparam logic [PS_W-1:0] PART_TUPLE    = 3'd0;
    localparam logic [PS_W-1:0] PART_SRC_HIGH = 3'd1;
    localparam logic [PS_W-1:0] PART_SRC_LOW  = 3'd2;
    localparam logic [PS_W-1:0] PART_DST_HIGH = 3'd3;
    localparam logic [PS_W-1:0] PART_DST_LOW  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic load_key;
        logic scan;
        logic capture;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit_zero;
        logic cmp_valid;
        logic cmp_hit;
        logic cmp_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### design/ipv6c_ifs.sv
// Channel interfaces of the IPv6 five-tuple mask classifier: input items,
// results and the configuration write channel.
// Depends on ipv6c_pkg.
`default_nettype none

interface ipv6c_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [ipv6c_pkg::RI_W-1:0]        rule_index;
    logic [ipv6c_pkg::PS_W-1:0]        part_select;
    logic [ipv6c_pkg::WORD_W-1:0]      part_value;
    logic [ipv6c_pkg::WORD_W-1:0]      part_mask;
    logic [7:0]                        protocol;
    logic [15:0]                       source_port;
    logic [15:0]                       dest_port;
    logic [ipv6c_pkg::WORD_W-1:0]      source_addr_high;
    logic [ipv6c_pkg::WORD_W-1:0]      source_addr_low;
    logic [ipv6c_pkg::WORD_W-1:0]      dest_addr_high;
    logic [ipv6c_pkg::WORD_W-1:0]      dest_addr_low;

    modport source (
        output valid, kind, rule_index, part_select, part_value, part_mask,
               protocol, source_port, dest_port, source_addr_high,
               source_addr_low, dest_addr_high, dest_addr_low,
        input  ready
    );
    modport sink (
        input  valid, kind, rule_index, part_select, part_value, part_mask,
               protocol, source_port, dest_port, source_addr_high,
               source_addr_low, dest_addr_high, dest_addr_low,
        output ready
    );
endinterface

interface ipv6c_out_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [ipv6c_pkg::MI_W-1:0]  match_index;

    modport source (output valid, hit, match_index, input ready);
    modport sink   (input valid, hit, match_index, output ready);
endinterface

interface ipv6c_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ipv6c_pkg::CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### design/ipv6c_ctrl.sv
// Controller of the IPv6 five-tuple mask classifier: accepts beats,
// sequences the rule scan and hands results to the output register.
// Depends on ipv6c_pkg.
`default_nettype none

module ipv6c_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_kind,
    output logic                    o_in_ready,
    input  wire ipv6c_pkg::t_status i_status,
    output ipv6c_pkg::t_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.write    = in_fire && (i_kind == ipv6c_pkg::KIND_WRITE);
                o_cmd.load_key = in_fire && (i_kind == ipv6c_pkg::KIND_CLASSIFY);
                if (o_cmd.load_key) begin
                    n_state = i_status.limit_zero ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan    = 1'b1;
                o_cmd.capture = i_status.cmp_valid && i_status.cmp_hit;
                if (i_status.cmp_valid && (i_status.cmp_hit || i_status.cmp_last)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.publish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/ipv6c_datapath.sv
// Datapath of the IPv6 five-tuple mask classifier: rule memories, key
// register, scan counter, match compare, result and output registers.
// Depends on ipv6c_pkg.
`default_nettype none

module ipv6c_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ipv6c_pkg::t_cmd               i_cmd,
    output ipv6c_pkg::t_status                 o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipv6c_pkg::CNT_W-1:0]   i_cfg_data,
    input  wire logic [ipv6c_pkg::RI_W-1:0]    i_rule_index,
    input  wire logic [ipv6c_pkg::PS_W-1:0]    i_part_select,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_part_value,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_part_mask,
    input  wire logic [7:0]                    i_protocol,
    input  wire logic [15:0]                   i_source_port,
    input  wire logic [15:0]                   i_dest_port,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_source_addr_high,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_source_addr_low,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_dest_addr_high,
    input  wire logic [ipv6c_pkg::WORD_W-1:0]  i_dest_addr_low,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_out_hit,
    output logic [ipv6c_pkg::MI_W-1:0]         o_out_match_index
);

    localparam int PARTS  = ipv6c_pkg::PARTS;
    localparam int IDX_W  = ipv6c_pkg::IDX_W;
    localparam int SCAN_W = ipv6c_pkg::SCAN_W;
    localparam int WORD_W = ipv6c_pkg::WORD_W;
    localparam int MI_W   = ipv6c_pkg::MI_W;
    localparam int PS_W   = ipv6c_pkg::PS_W;

    logic [ipv6c_pkg::CNT_W-1:0] r_cfg;
    logic [31:0]                 cfg32;
    logic [31:0]                 lim32;
    logic [SCAN_W-1:0]           limit;

    logic [WORD_W-1:0]           r_key [PARTS];

    logic [31:0]                 ri32;
    logic [IDX_W-1:0]            wr_addr;
    logic                        wr_ok;

    logic [IDX_W-1:0]            r_addr;
    logic                        r_issue_done;
    logic                        rd_en;
    logic                        r_cmp_v;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic [PARTS-1:0]            part_ok;
    logic [31:0]                 cmp_idx32;

    logic                        r_res_hit;
    logic [MI_W-1:0]             r_res_idx;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [MI_W-1:0]             r_out_idx;

    // Rule count register, clamped to the table size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    assign cfg32 = 32'(r_cfg);
    assign lim32 = (cfg32 > ipv6c_pkg::RULES_U) ? ipv6c_pkg::RULES_U : cfg32;
    assign limit = lim32[SCAN_W-1:0];

    // Write address decode; writes outside the table or the part range drop.
    assign ri32    = 32'(i_rule_index);
    assign wr_addr = ri32[IDX_W-1:0];
    assign wr_ok   = i_cmd.write && (ri32 < ipv6c_pkg::RULES_U) &&
                     (i_part_select < PS_W'(PARTS));

    // Key register, built in the same packing as the stored rule parts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key[ipv6c_pkg::PART_TUPLE]    <= {24'd0, i_protocol, i_source_port, i_dest_port};
            r_key[ipv6c_pkg::PART_SRC_HIGH] <= i_source_addr_high;
            r_key[ipv6c_pkg::PART_SRC_LOW]  <= i_source_addr_low;
            r_key[ipv6c_pkg::PART_DST_HIGH] <= i_dest_addr_high;
            r_key[ipv6c_pkg::PART_DST_LOW]  <= i_dest_addr_low;
        end
    end

    // Scan address counter: one rule read per cycle up to the limit.
    assign rd_en = i_cmd.scan && !r_issue_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_done <= 1'b1;
            r_cmp_v      <= 1'b0;
        end else if (i_cmd.load_key) begin
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_cmp_v      <= 1'b0;
        end else begin
            r_cmp_v <= rd_en;
            if (rd_en) begin
                r_addr       <= r_addr + 1'b1;
                r_issue_done <= (32'(r_addr) + 32'd1 == 32'(limit));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmp_idx <= r_addr;
        end
    end

    // One memory pair per rule part; all five are read at the scan address.
    for (genvar p = 0; p < PARTS; p++) begin : g_part
        logic [WORD_W-1:0] r_val_mem [ipv6c_pkg::RULES];
        logic [WORD_W-1:0] r_msk_mem [ipv6c_pkg::RULES];
        logic [WORD_W-1:0] r_rd_val;
        logic [WORD_W-1:0] r_rd_msk;

        always_ff @(posedge i_clk) begin
            if (wr_ok && (i_part_select == PS_W'(p))) begin
                r_val_mem[wr_addr] <= i_part_value & i_part_mask;
                r_msk_mem[wr_addr] <= i_part_mask;
            end
            if (rd_en) begin
                r_rd_val <= r_val_mem[r_addr];
                r_rd_msk <= r_msk_mem[r_addr];
            end
        end

        assign part_ok[p] = ((r_key[p] & r_rd_msk) == r_rd_val);
    end

    // Status toward the controller.
    assign cmp_idx32           = 32'(r_cmp_idx);
    assign o_status.limit_zero = (limit == '0);
    assign o_status.cmp_valid  = r_cmp_v;
    assign o_status.cmp_hit    = &part_ok;
    assign o_status.cmp_last   = (cmp_idx32 + 32'd1 == 32'(limit));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Result register: preset to a miss when the key loads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_res_hit <= 1'b0;
            r_res_idx <= ipv6c_pkg::MISS_INDEX;
        end else if (i_cmd.capture) begin
            r_res_hit <= 1'b1;
            r_res_idx <= cmp_idx32[MI_W-1:0];
        end
    end

    // Output register holding one result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_hit <= r_res_hit;
            r_out_idx <= r_res_idx;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_hit         = r_out_hit;
    assign o_out_match_index = r_out_idx;

endmodule

`default_nettype wire

### design/ipv6_five_tuple_mask_classifier.sv
// IPv6 five-tuple masked first-match classifier, top level.
// A write beat is taken and gives no result. A classify beat scans the
// rule memories one rule per cycle (one read port per part); a first match ends the scan
// early, a miss scans every rule up to the count, and a count of zero skips the scan.
// The next beat can be taken in the same cycle that the result enters the output register.
// Synchronous active-low reset clears control state and the rule count; rule memory is not cleared.
`default_nettype none

module ipv6_five_tuple_mask_classifier (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ipv6c_in_if.sink     i_in,
    ipv6c_out_if.source  o_out,
    ipv6c_cfg_if.sink    i_cfg
);

    ipv6c_pkg::t_cmd    cmd;
    ipv6c_pkg::t_status status;
    logic               in_ready;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    ipv6c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ipv6c_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_data         (i_cfg.data),
        .i_rule_index       (i_in.rule_index),
        .i_part_select      (i_in.part_select),
        .i_part_value       (i_in.part_value),
        .i_part_mask        (i_in.part_mask),
        .i_protocol         (i_in.protocol),
        .i_source_port      (i_in.source_port),
        .i_dest_port        (i_in.dest_port),
        .i_source_addr_high (i_in.source_addr_high),
        .i_source_addr_low  (i_in.source_addr_low),
        .i_dest_addr_high   (i_in.dest_addr_high),
        .i_dest_addr_low    (i_in.dest_addr_low),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_out_hit          (o_out.hit),
        .o_out_match_index  (o_out.match_index)
    );

`ifndef SYNTHESIS
    // A miss always reports the table size as its index.
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |-> (o_out.match_index == ipv6c_pkg::MISS_INDEX))
        else $error("miss result carries a wrong index");

    // No input beat is taken while a scan is running.
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> !i_in.ready)
        else $error("input ready during a scan");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_out.valid || o_out.ready))
        else $error("result published over a pending beat");

    // After a classify beat the input closes until its result is out.
    a_busy_after_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.kind == ipv6c_pkg::KIND_CLASSIFY))
        |=> !i_in.ready)
        else $error("input reopened right after a classify beat");
`endif

endmodule

`default_nettype wire
